@@ sv/mf2d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants and types of the 2-D median filter: field widths,
// configuration register codes and the per-word control record.
// ----------------------------------------------------------------------------
package mf2d_pkg;

    // Fixed field widths of the stream and of the configuration registers
    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 12;
    localparam int CFG_DATA_W   = 12;
    localparam int CFG_IDX_W    = 2;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    // What the frame sequencer decides for one input word
    typedef struct packed {
        logic produce;   // word releases an output pixel
        logic interior;  // that pixel takes the window median
        logic last;      // that pixel closes the frame
    } t_item_ctl;

endpackage

@@ sv/mf2d_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_in_if
// Input pixel stream: valid/ready handshake carrying one raster pixel.
// ----------------------------------------------------------------------------
interface mf2d_in_if;
    import mf2d_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

@@ sv/mf2d_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_out_if
// Output pixel stream: valid/ready handshake carrying a filtered pixel and
// the end-of-frame flag.
// ----------------------------------------------------------------------------
interface mf2d_out_if;
    import mf2d_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] out_pixel;
    logic             frame_last;

    modport source (output valid, output out_pixel, output frame_last, input ready);
    modport sink   (input valid, input out_pixel, input frame_last, output ready);
endinterface

@@ sv/mf2d_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered, read-first output.
// ----------------------------------------------------------------------------
module mf2d_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

@@ sv/mf2d_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_seq
// Frame sequencer: holds the size registers, the input column, the warm-up
// count and the output position, and classifies each input word.
// ----------------------------------------------------------------------------
module mf2d_seq #(
    parameter int WINDOW    = 3,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_take,
    output logic [$clog2(MAX_WIDTH)-1:0]      o_col,
    output mf2d_pkg::t_item_ctl               o_ctl
);
    import mf2d_pkg::*;

    localparam int HALF = WINDOW / 2;
    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int WB   = $clog2(MAX_WIDTH + 1);
    localparam int XW   = ((WB > CFG_HEIGHT_W) ? WB : CFG_HEIGHT_W) + 1;
    localparam int LAGW = $clog2(HALF * MAX_WIDTH + HALF + 1);

    logic [CFG_WIDTH_W-1:0]  r_width,   n_width;
    logic [CFG_HEIGHT_W-1:0] r_height,  n_height;
    logic [LAGW-1:0]         r_cnt,     n_cnt;
    logic [CW-1:0]           r_in_col,  n_in_col;
    logic [CFG_HEIGHT_W-1:0] r_out_row, n_out_row;
    logic [CW-1:0]           r_out_col, n_out_col;

    logic [XW-1:0]   w_raw, w_eff, h_raw, h_eff;
    logic [XW-1:0]   row_x, col_x, in_col_x;
    logic [LAGW-1:0] lag;
    logic            restart;

    // effective frame size: zero counts as one, width clamps to the store
    always_comb begin
        w_raw = XW'(r_width);
        h_raw = XW'(r_height);
        if (w_raw == '0) begin
            w_eff = XW'(1);
        end else if (w_raw > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = w_raw;
        end
        h_eff    = (h_raw == '0) ? XW'(1) : h_raw;
        lag      = LAGW'(HALF) * LAGW'(w_eff) + LAGW'(HALF);
        row_x    = XW'(r_out_row);
        col_x    = XW'(r_out_col);
        in_col_x = XW'(r_in_col);
    end

    always_comb begin
        o_col          = r_in_col;
        o_ctl.produce  = (r_cnt >= lag);
        o_ctl.interior = (row_x >= XW'(HALF)) && (row_x + XW'(HALF) < h_eff) &&
                         (col_x >= XW'(HALF)) && (col_x + XW'(HALF) < w_eff);
        o_ctl.last     = o_ctl.produce && (row_x == h_eff - XW'(1)) &&
                         (col_x == w_eff - XW'(1));
    end

    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_cnt     = r_cnt;
        n_in_col  = r_in_col;
        n_out_row = r_out_row;
        n_out_col = r_out_col;
        restart   = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_IMAGE_WIDTH: begin
                    n_width = i_cfg_data[CFG_WIDTH_W-1:0];
                    restart = 1'b1;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height = i_cfg_data[CFG_HEIGHT_W-1:0];
                    restart  = 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_take) begin
            if (o_ctl.last) begin
                restart = 1'b1;
            end else begin
                n_in_col = (in_col_x == w_eff - XW'(1)) ? '0 : r_in_col + CW'(1);
                if (!o_ctl.produce) begin
                    n_cnt = r_cnt + LAGW'(1);
                end else if (col_x == w_eff - XW'(1)) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + CFG_HEIGHT_W'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
        end
        if (restart) begin
            n_cnt     = '0;
            n_in_col  = '0;
            n_out_row = '0;
            n_out_col = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= CFG_WIDTH_W'(WIDTH_RESET);
            r_height  <= CFG_HEIGHT_W'(HEIGHT_RESET);
            r_cnt     <= '0;
            r_in_col  <= '0;
            r_out_row <= '0;
            r_out_col <= '0;
        end else begin
            r_width   <= n_width;
            r_height  <= n_height;
            r_cnt     <= n_cnt;
            r_in_col  <= n_in_col;
            r_out_row <= n_out_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

@@ sv/mf2d_median.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_median
// Median of a square window by parallel ranking: every sample is compared
// with every other, and the sample whose rank is the middle one is selected.
// ----------------------------------------------------------------------------
module mf2d_median #(
    parameter int WINDOW     = 3,
    parameter int PIXEL_BITS = 8
) (
    input  logic [WINDOW*WINDOW*PIXEL_BITS-1:0] i_win,
    output logic [PIXEL_BITS-1:0]               o_med
);

    localparam int AREA = WINDOW * WINDOW;
    localparam int RW   = $clog2(AREA + 1);
    localparam int MID  = AREA / 2;

    logic [PIXEL_BITS-1:0] val [AREA];
    logic [AREA-1:0]       below [AREA];
    logic [AREA-1:0]       pick;

    always_comb begin
        for (int i = 0; i < AREA; i++) begin
            val[i] = i_win[i*PIXEL_BITS +: PIXEL_BITS];
        end
    end

    // equal samples are ordered by position, so ranks form a permutation
    always_comb begin
        for (int i = 0; i < AREA; i++) begin
            for (int j = 0; j < AREA; j++) begin
                below[i][j] = (val[j] < val[i]) || ((val[j] == val[i]) && (j < i));
            end
        end
    end

    always_comb begin
        for (int i = 0; i < AREA; i++) begin
            pick[i] = (RW'($countones(below[i])) == RW'(MID));
        end
    end

    always_comb begin
        o_med = '0;
        for (int i = 0; i < AREA; i++) begin
            o_med = o_med | (val[i] & {PIXEL_BITS{pick[i]}});
        end
    end

endmodule

@@ sv/median_filter_2d.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_filter_2d
// Streaming WINDOW x WINDOW median filter over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// The block takes one pixel word per clock and gives one filtered pixel per
// clock once warm, while the output is not stalled; a word's result passes
// through the input register (line store read), the window register and the
// output register. The output stream lags the input by HALF*width + HALF
// words, HALF being WINDOW/2; the first words of a frame give no result, and
// after the last pixel of the frame the host sends that many trailing words
// whose values are ignored. Pixels whose full window lies inside the frame
// take the window median; pixels within HALF of an edge come out unchanged.
// frame_last marks the final pixel. Writing either size register restarts
// the frame; write only while the stream is idle. The line store needs no
// clearing after reset: rows read before they are written in the current
// frame only reach the windows of edge pixels, which give their centre.
// ----------------------------------------------------------------------------
module median_filter_2d #(
    parameter int WINDOW     = 3,
    parameter int MAX_WIDTH  = 1024,
    parameter int PIXEL_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mf2d_in_if.sink                         i_pix,
    mf2d_out_if.source                      o_pix,
    input  logic                            i_cfg_we,
    input  logic [mf2d_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mf2d_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mf2d_pkg::*;

    localparam int HALF  = WINDOW / 2;
    localparam int AREA  = WINDOW * WINDOW;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int LB_W  = (WINDOW - 1) * PIXEL_BITS;   // rows held in the line store
    localparam int COL_W = WINDOW * PIXEL_BITS;         // one vertical column of the window

    // sequencer view of the word being offered
    logic            take;
    logic [CW-1:0]   seq_col;
    t_item_ctl       seq_ctl;

    // input stage: word registered, line store data arriving alongside
    logic                  r_a_valid, n_a_valid;
    logic [PIXEL_BITS-1:0] r_a_pix;
    logic [CW-1:0]         r_a_col;
    t_item_ctl             r_a_ctl;
    logic                  r_byp_hit;
    logic [LB_W-1:0]       r_byp_data;
    logic [LB_W-1:0]       lb_rdata;
    logic [LB_W-1:0]       a_above;
    logic [COL_W-1:0]      a_column;

    // window stage
    logic [COL_W-1:0]           r_win [WINDOW];
    logic                       r_b_valid, n_b_valid;
    t_item_ctl                  r_b_ctl;
    logic [AREA*PIXEL_BITS-1:0] win_flat;
    logic [PIXEL_BITS-1:0]      med;
    logic [PIXEL_BITS-1:0]      centre;
    logic [PIXEL_BITS-1:0]      b_result;

    // output register
    logic             r_o_valid, n_o_valid;
    logic [PIX_W-1:0] r_o_pix;
    logic             r_o_last;

    logic adv_a, adv_b;

    // ---- handshake ------------------------------------------------------
    // A word that gives no result passes the window stage without waiting on
    // the output side; the output register takes a new result in the same cycle
    // that the waiting one is taken.
    assign adv_b       = r_b_valid && (!r_b_ctl.produce || !r_o_valid || o_pix.ready);
    assign adv_a       = r_a_valid && (!r_b_valid || adv_b);
    assign i_pix.ready = !r_a_valid || adv_a;
    assign take        = i_pix.valid && i_pix.ready;

    mf2d_seq #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_take     (take),
        .o_col      (seq_col),
        .o_ctl      (seq_ctl)
    );

    // ---- line store -------------------------------------------------------
    // One entry per column holds the WINDOW-1 rows above the current one.
    // Read at the column of the word being accepted; write back the shifted
    // column when that word leaves the input stage.
    mf2d_ram #(
        .DATA_W (LB_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (adv_a),
        .i_waddr (r_a_col),
        .i_wdata (a_column[COL_W-1:PIXEL_BITS]),
        .i_re    (take),
        .i_raddr (seq_col),
        .o_rdata (lb_rdata)
    );

    // A write to the very column being read in the same cycle (single-column
    // frames) is missed by the read-first RAM: forward it from the bypass copy.
    assign a_above  = r_byp_hit ? r_byp_data : lb_rdata;
    assign a_column = {r_a_pix, a_above};   // oldest row in the low bits

    // ---- window and result -------------------------------------------------
    always_comb begin
        win_flat = '0;
        for (int c = 0; c < WINDOW; c++) begin
            for (int r = 0; r < WINDOW; r++) begin
                win_flat[(c*WINDOW + r)*PIXEL_BITS +: PIXEL_BITS] =
                    r_win[c][r*PIXEL_BITS +: PIXEL_BITS];
            end
        end
    end

    mf2d_median #(
        .WINDOW     (WINDOW),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_win (win_flat),
        .o_med (med)
    );

    // the centre of the window is the pixel at the output position
    assign centre   = r_win[HALF][HALF*PIXEL_BITS +: PIXEL_BITS];
    assign b_result = r_b_ctl.interior ? med : centre;

    // ---- valid flags -------------------------------------------------------
    always_comb begin
        n_a_valid = r_a_valid;
        if (take) begin
            n_a_valid = 1'b1;
        end else if (adv_a) begin
            n_a_valid = 1'b0;
        end

        n_b_valid = r_b_valid;
        if (adv_a) begin
            n_b_valid = 1'b1;
        end else if (adv_b) begin
            n_b_valid = 1'b0;
        end

        n_o_valid = r_o_valid;
        if (adv_b && r_b_ctl.produce) begin
            n_o_valid = 1'b1;
        end else if (o_pix.ready) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= n_a_valid;
            r_b_valid <= n_b_valid;
            r_o_valid <= n_o_valid;
        end
    end

    // ---- payload -----------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_a_pix    <= PIXEL_BITS'(i_pix.pixel);
            r_a_col    <= seq_col;
            r_a_ctl    <= seq_ctl;
            r_byp_hit  <= adv_a && (r_a_col == seq_col);
            r_byp_data <= a_column[COL_W-1:PIXEL_BITS];
        end
        // advance the window by one column for every word, result or not
        if (adv_a) begin
            for (int i = 0; i < WINDOW - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
            r_win[WINDOW-1] <= a_column;
            r_b_ctl         <= r_a_ctl;
        end
        if (adv_b && r_b_ctl.produce) begin
            r_o_pix  <= PIX_W'(b_result);
            r_o_last <= r_b_ctl.last;
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.out_pixel  = r_o_pix;
    assign o_pix.frame_last = r_o_last;

endmodule

@@ sv/mf2d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf2d_checker
// Port-level checks of the median filter, bound to the top level.
// ----------------------------------------------------------------------------
module mf2d_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [mf2d_pkg::PIX_W-1:0] i_out_pixel,
    input logic                       i_out_last
);
    import mf2d_pkg::*;

    // reset empties the pipeline: no result afterwards
    a_reset_clears_out : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // reset leaves the input stage free to take a word
    a_reset_ready : assert property (@(posedge i_clk)
        !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_out_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output word dropped while stalled");

    a_out_hold_data : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_pixel) && $stable(i_out_last))
        else $error("output word changed while stalled");

endmodule

bind median_filter_2d mf2d_checker u_mf2d_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_pixel (o_pix.out_pixel),
    .i_out_last  (o_pix.frame_last)
);
